// File: rtl/toeq_pkg.sv
package toeq_pkg;

  // Field widths of one event, the status code and the occupancy
  localparam int TimeW   = 16;
  localparam int KindW   = 3;
  localparam int NodeW   = 11;
  localparam int LinkW   = 13;
  localparam int StatusW = 2;
  localparam int OccW    = 5;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;   // capture the input transaction
    logic do_insert; // shift cells and place the new event
    logic do_pop;    // shift cells toward the head
    logic load_out;  // capture the result transaction
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op_pop;
    logic full;
    logic empty;
  } sts_t;

endpackage

// File: rtl/toeq_ctrl.sv
module toeq_ctrl
  import toeq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result register can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.do_insert = !sts_i.op_pop && !sts_i.full;
          cmd_o.do_pop    = sts_i.op_pop && !sts_i.empty;
        end
      end
      default: ;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/toeq_datapath.sv
module toeq_datapath
  import toeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic                    op_i,
  input  logic        [TimeW-1:0] event_time_i,
  input  logic        [KindW-1:0] event_kind_i,
  input  logic signed [NodeW-1:0] event_node_i,
  input  logic signed [LinkW-1:0] event_link_i,
  output status_e                 status_o,
  output logic        [TimeW-1:0] out_time_o,
  output logic        [KindW-1:0] out_kind_o,
  output logic signed [NodeW-1:0] out_node_o,
  output logic signed [LinkW-1:0] out_link_o,
  output logic        [OccW-1:0]  occupancy_o
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  // Captured input transaction
  logic             op_q;
  logic [TimeW-1:0] in_time_q;
  logic [KindW-1:0] in_kind_q;
  logic [NodeW-1:0] in_node_q;
  logic [LinkW-1:0] in_link_q;

  // Sorted cells, head at index 0
  logic [TimeW-1:0] time_q [QUEUE_DEPTH];
  logic [KindW-1:0] kind_q [QUEUE_DEPTH];
  logic [NodeW-1:0] node_q [QUEUE_DEPTH];
  logic [LinkW-1:0] link_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] later;

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW+OccW-1:0] occ_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q      <= op_i;
      in_time_q <= event_time_i;
      in_kind_q <= event_kind_i;
      in_node_q <= event_node_i;
      in_link_q <= event_link_i;
    end
  end

  assign sts_o.op_pop = (op_q == OP_POP);
  assign sts_o.full   = (cnt_q == CntW'(QUEUE_DEPTH));
  assign sts_o.empty  = (cnt_q == '0);

  // Each occupied cell flags a stored time strictly later than the new one
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      later[i] = (CntW'(i) < cnt_q) && (time_q[i] > in_time_q);
    end
  end

  // Per-cell update: insert shifts later events back, pop shifts toward head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             from_prev;
    logic             take_new;
    logic [TimeW-1:0] prev_time, next_time;
    logic [KindW-1:0] prev_kind, next_kind;
    logic [NodeW-1:0] prev_node, next_node;
    logic [LinkW-1:0] prev_link, next_link;

    if (i == 0) begin : g_first
      assign from_prev = 1'b0;
      assign prev_time = in_time_q;
      assign prev_kind = in_kind_q;
      assign prev_node = in_node_q;
      assign prev_link = in_link_q;
    end else begin : g_rest
      assign from_prev = later[i-1];
      assign prev_time = time_q[i-1];
      assign prev_kind = kind_q[i-1];
      assign prev_node = node_q[i-1];
      assign prev_link = link_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_time = time_q[i];
      assign next_kind = kind_q[i];
      assign next_node = node_q[i];
      assign next_link = link_q[i];
    end else begin : g_inner
      assign next_time = time_q[i+1];
      assign next_kind = kind_q[i+1];
      assign next_node = node_q[i+1];
      assign next_link = link_q[i+1];
    end

    // First later cell, or first free cell, receives the new event
    assign take_new = later[i] || (CntW'(i) == cnt_q);

    always_ff @(posedge clk_i) begin
      if (cmd_i.do_insert) begin
        if (from_prev) begin
          time_q[i] <= prev_time;
          kind_q[i] <= prev_kind;
          node_q[i] <= prev_node;
          link_q[i] <= prev_link;
        end else if (take_new) begin
          time_q[i] <= in_time_q;
          kind_q[i] <= in_kind_q;
          node_q[i] <= in_node_q;
          link_q[i] <= in_link_q;
        end
      end else if (cmd_i.do_pop) begin
        time_q[i] <= next_time;
        kind_q[i] <= next_kind;
        node_q[i] <= next_node;
        link_q[i] <= next_link;
      end
    end
  end

  // Fill count
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.do_insert) cnt_d = cnt_q + CntW'(1);
    else if (cmd_i.do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign occ_ext = {{OccW{1'b0}}, cnt_d};

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      occupancy_o <= occ_ext[OccW-1:0];
      out_time_o  <= '0;
      out_kind_o  <= '0;
      out_node_o  <= '0;
      out_link_o  <= '0;
      status_o    <= STATUS_OK;
      if (sts_o.op_pop) begin
        if (sts_o.empty) begin
          status_o <= STATUS_EMPTY;
        end else begin
          out_time_o <= time_q[0];
          out_kind_o <= kind_q[0];
          out_node_o <= node_q[0];
          out_link_o <= link_q[0];
        end
      end else if (sts_o.full) begin
        status_o <= STATUS_FULL;
      end
    end
  end

endmodule

// File: rtl/time_ordered_event_queue_core.sv
// Time-ordered event queue.
// Input channel (in_valid_i / in_stall_o) carries one operation per
// transaction: op_i = 0 inserts the event given by event_time_i,
// event_kind_i, event_node_i, event_link_i; op_i = 1 pops the earliest event.
// Events with equal times leave in arrival order.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// operation: status_o (ok, insert dropped because full, pop on empty), the
// popped event (zeros otherwise) and occupancy_o after the operation.
// Each operation is captured, then applied in the update state once the
// output register is free; no new one is taken until it is through capture
// and the single update of the sorted cell array, where every cell compares
// its time to the new one in parallel.
// The input is taken again while a result waits in the output register;
// when the receiver stalls with a result pending, the next operation is
// held in the update stage and the input stalls until the result leaves.
// Reset empties the queue (fill count zero); no clearing pass is needed.
module time_ordered_event_queue_core
  import toeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    op_i,
  input  logic        [TimeW-1:0] event_time_i,
  input  logic        [KindW-1:0] event_kind_i,
  input  logic signed [NodeW-1:0] event_node_i,
  input  logic signed [LinkW-1:0] event_link_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic        [StatusW-1:0] status_o,
  output logic        [TimeW-1:0] out_time_o,
  output logic        [KindW-1:0] out_kind_o,
  output logic signed [NodeW-1:0] out_node_o,
  output logic signed [LinkW-1:0] out_link_o,
  output logic        [OccW-1:0]  occupancy_o
);

  cmd_t    cmd;
  sts_t    sts;
  status_e status;

  toeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  toeq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (op_i),
    .event_time_i (event_time_i),
    .event_kind_i (event_kind_i),
    .event_node_i (event_node_i),
    .event_link_i (event_link_i),
    .status_o     (status),
    .out_time_o   (out_time_o),
    .out_kind_o   (out_kind_o),
    .out_node_o   (out_node_o),
    .out_link_o   (out_link_o),
    .occupancy_o  (occupancy_o)
  );

  assign status_o = status;

endmodule

// File: rtl/toeq_checker.sv
module toeq_checker
  import toeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic      [StatusW-1:0] status_o,
  input logic        [TimeW-1:0] out_time_o,
  input logic        [KindW-1:0] out_kind_o,
  input logic signed [NodeW-1:0] out_node_o,
  input logic signed [LinkW-1:0] out_link_o,
  input logic        [OccW-1:0]  occupancy_o
);

  localparam logic [OccW+8:0] DepthExt = (OccW + 9)'(QUEUE_DEPTH);

  // One operation at a time: an accepted transaction blocks the next edge
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on consecutive edges");

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // An error result carries no event
  a_err_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_FULL || status_o == STATUS_EMPTY) |->
      out_time_o == '0 && out_kind_o == '0 && out_node_o == '0 && out_link_o == '0)
    else $error("payload on failed operation");

  // Status codes and occupancy agree
  a_status_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (status_o != 2'd3) &&
      (status_o != STATUS_FULL  || occupancy_o == DepthExt[OccW-1:0]) &&
      (status_o != STATUS_EMPTY || occupancy_o == '0))
    else $error("status inconsistent with occupancy");

endmodule

bind time_ordered_event_queue_core toeq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_toeq_checker (.*);

// File: tb/sv/time_ordered_event_queue_core_tb.sv
module time_ordered_event_queue_core_tb;
  import toeq_pkg::*;

  localparam int Depth      = 16;
  localparam int CycleLimit = 300000;
  localparam int RandomOps  = 800;

  // One stored event and one returned result
  typedef struct packed {
    logic        [TimeW-1:0] stamp;
    logic        [KindW-1:0] kind;
    logic signed [NodeW-1:0] node;
    logic signed [LinkW-1:0] link;
  } event_t;

  typedef struct packed {
    status_e         status;
    event_t          ev;
    logic [OccW-1:0] occ;
  } result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      op;
  logic         [TimeW-1:0]  ev_time;
  logic         [KindW-1:0]  ev_kind;
  logic signed  [NodeW-1:0]  ev_node;
  logic signed  [LinkW-1:0]  ev_link;
  logic                      out_valid;
  logic                      out_stall;
  logic         [StatusW-1:0] status;
  logic         [TimeW-1:0]  out_time;
  logic         [KindW-1:0]  out_kind;
  logic signed  [NodeW-1:0]  out_node;
  logic signed  [LinkW-1:0]  out_link;
  logic         [OccW-1:0]   occupancy;

  // Sorted copy of the queue contents and the results still owed by the block
  event_t  sorted_events[$];
  result_t owed_results[$];

  int errors       = 0;
  int cycles       = 0;
  int burst_left   = 0;
  int n_inserts    = 0;
  int n_pops       = 0;
  int n_full       = 0;
  int n_empty      = 0;
  int n_checked    = 0;
  int max_occ_seen = 0;

  time_ordered_event_queue_core #(
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .event_time_i (ev_time),
    .event_kind_i (ev_kind),
    .event_node_i (ev_node),
    .event_link_i (ev_link),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .out_time_o   (out_time),
    .out_kind_o   (out_kind),
    .out_node_o   (out_node),
    .out_link_o   (out_link),
    .occupancy_o  (occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, owed_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver stall: random switching among four stall modes
  int stall_mode = 0;
  int mode_left  = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(10, 80);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ((cycles % 8) < 5);
    endcase
  end

  // Queue behavior: stable sorted insert, pop from head
  function automatic result_t apply_queue_op(logic opcode, event_t ev);
    result_t r;
    int      pos;
    r.status = STATUS_OK;
    r.ev     = '0;
    if (opcode == OP_INSERT) begin
      if (sorted_events.size() >= Depth) begin
        r.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_events.size() && sorted_events[pos].stamp <= ev.stamp) pos++;
        sorted_events.insert(pos, ev);
      end
    end else if (sorted_events.size() == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.ev = sorted_events.pop_front();
    end
    r.occ = OccW'(sorted_events.size());
    return r;
  endfunction

  // Send one transaction; bursts with random gaps between them
  task automatic send_op(input logic opcode, input event_t ev);
    result_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
      repeat ($urandom_range(0, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    op       <= opcode;
    ev_time  <= ev.stamp;
    ev_kind  <= ev.kind;
    ev_node  <= ev.node;
    ev_link  <= ev.link;
    do @(posedge clk); while (in_stall);
    r = apply_queue_op(opcode, ev);
    owed_results.push_back(r);
    if (opcode == OP_INSERT) n_inserts++;
    else n_pops++;
    if (r.status == STATUS_FULL) n_full++;
    if (r.status == STATUS_EMPTY) n_empty++;
    if (r.occ > max_occ_seen) max_occ_seen = r.occ;
  endtask

  // Hold the input low until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic event_t mk_event(int t, int k, int n, int l);
    event_t e;
    e.stamp = TimeW'(t);
    e.kind  = KindW'(k);
    e.node  = NodeW'(n);
    e.link  = LinkW'(l);
    return e;
  endfunction

  // Random content; narrow times give plenty of ties
  function automatic event_t rand_event();
    int t;
    t = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 65535);
    return mk_event(t, $urandom_range(0, 7), $urandom_range(0, 2047), $urandom_range(0, 8191));
  endfunction

  // Result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, status %0d occupancy %0d",
                 $time, status, occupancy);
      end else begin
        want = owed_results.pop_front();
        n_checked++;
        if (status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        end
        if (out_time !== want.ev.stamp) begin
          errors++;
          $display("%0t: time expected %0d actual %0d", $time, want.ev.stamp, out_time);
        end
        if (out_kind !== want.ev.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, want.ev.kind, out_kind);
        end
        if (out_node !== want.ev.node) begin
          errors++;
          $display("%0t: node expected %0d actual %0d", $time, want.ev.node, out_node);
        end
        if (out_link !== want.ev.link) begin
          errors++;
          $display("%0t: link expected %0d actual %0d", $time, want.ev.link, out_link);
        end
        if (occupancy !== want.occ) begin
          errors++;
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occupancy);
        end
      end
    end
  end

  // Pop on an empty queue right after reset
  task automatic test_pop_empty();
    send_op(OP_POP, rand_event());
  endtask

  // Largest and smallest values of every field, signed ends included
  task automatic test_field_extremes();
    send_op(OP_INSERT, mk_event(65535, 7, 1023, 4095));
    send_op(OP_INSERT, mk_event(0, 0, -1, -1));
    send_op(OP_INSERT, mk_event(32768, 5, -1024, -4096));
    send_op(OP_INSERT, mk_event(1, 2, 0, 0));
    send_op(OP_POP, rand_event());
    send_op(OP_POP, rand_event());
  endtask

  // Equal times leave in arrival order, behind an already stored equal time
  task automatic test_equal_times();
    send_op(OP_INSERT, mk_event(32768, 1, 11, 101));
    send_op(OP_INSERT, mk_event(32768, 2, 22, 202));
    send_op(OP_INSERT, mk_event(32768, 3, 33, 303));
    send_op(OP_POP, rand_event());
  endtask

  // Fill to the top, then one insert that must be dropped
  task automatic test_fill_overflow();
    while (sorted_events.size() < Depth) send_op(OP_INSERT, rand_event());
    send_op(OP_INSERT, rand_event());
  endtask

  // Random mix in phases that lean toward full, balanced or empty
  task automatic test_random_mix(input int count);
    int insert_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      if (i == count / 2) drain_results();
      send_op(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP, rand_event());
    end
  endtask

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    out_stall = 1'b0;
    op        = OP_INSERT;
    ev_time   = '0;
    ev_kind   = '0;
    ev_node   = '0;
    ev_link   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pop_empty();
    test_field_extremes();
    test_equal_times();
    test_fill_overflow();
    test_random_mix(RandomOps);

    // Let the last results come back, then a short settle
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d inserts and %0d pops, %0d results checked.",
             n_inserts, n_pops, n_checked);
    $display("Dropped inserts on full: %0d, pops on empty: %0d, peak occupancy %0d.",
             n_full, n_empty, max_occ_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
